// File: rtl/core/csc_pkg.sv
package csc_pkg;

  // channel and difference widths
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned DIFF_W  = CHAN_W + 1;
  localparam int unsigned SQ_W    = 2 * CHAN_W;
  localparam int unsigned WGT_W   = 10;
  localparam int unsigned TERM_W  = WGT_W + SQ_W;
  localparam int unsigned DIST_W  = 28;

  // redmean weights, scaled by 256
  localparam int unsigned RED_BASE    = 512;
  localparam int unsigned BLUE_BASE   = 767;
  localparam int unsigned GREEN_SHIFT = 10;
  localparam int unsigned DIST_SHIFT  = 8;

  // configuration registers
  localparam int unsigned TOL_W      = 9;
  localparam int unsigned BRIGHT_W   = 8;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned TOL_SCALE  = 255;
  localparam int unsigned BOUND_W    = 17;
  localparam int unsigned BOUND_SQ_W = 34;

  localparam logic [TOL_W-1:0]      TOL_RST      = 9'd26;
  localparam logic [BRIGHT_W-1:0]   BRIGHT_RST   = 8'd20;
  localparam logic [BOUND_W-1:0]    BOUND_RST    = 17'd6630;
  localparam logic [BOUND_SQ_W-1:0] BOUND_SQ_RST = 34'd43956900;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE  = 1'b0,
    CFG_BRIGHTNESS = 1'b1
  } cfg_idx_e;

  // live configuration seen by the pipeline
  typedef struct packed {
    logic [BOUND_SQ_W-1:0] bound_sq;
    logic [BRIGHT_W-1:0]   bright;
  } cfg_t;

  // first stage: channel differences
  typedef struct packed {
    logic [CHAN_W-1:0]        dr;
    logic [CHAN_W-1:0]        dg;
    logic [CHAN_W-1:0]        db;
    logic signed [DIFF_W-1:0] sdr;
    logic signed [DIFF_W-1:0] sdg;
    logic signed [DIFF_W-1:0] sdb;
    logic [CHAN_W-1:0]        m;
    logic                     exact;
  } diff_t;

  // weighted distance terms
  typedef struct packed {
    logic [TERM_W-1:0] tr;
    logic [TERM_W-1:0] tg;
    logic [TERM_W-1:0] tb;
    logic              exact;
  } term_t;

endpackage

// File: rtl/core/csc_if.sv
// pixel pair channel
interface csc_pair_if;
  logic                        valid;
  logic                        ready;
  logic [csc_pkg::CHAN_W-1:0]  first_red;
  logic [csc_pkg::CHAN_W-1:0]  first_green;
  logic [csc_pkg::CHAN_W-1:0]  first_blue;
  logic [csc_pkg::CHAN_W-1:0]  second_red;
  logic [csc_pkg::CHAN_W-1:0]  second_green;
  logic [csc_pkg::CHAN_W-1:0]  second_blue;

  modport source (
    output valid, first_red, first_green, first_blue,
    output second_red, second_green, second_blue,
    input  ready
  );
  modport sink (
    input  valid, first_red, first_green, first_blue,
    input  second_red, second_green, second_blue,
    output ready
  );
endinterface

// similarity result channel
interface csc_result_if;
  logic                        valid;
  logic                        ready;
  logic                        similar;
  logic                        exact_match;
  logic                        within_distance;
  logic                        within_brightness;
  logic [csc_pkg::DIST_W-1:0]  scaled_distance_sq;

  modport source (
    output valid, similar, exact_match, within_distance, within_brightness,
    output scaled_distance_sq,
    input  ready
  );
  modport sink (
    input  valid, similar, exact_match, within_distance, within_brightness,
    input  scaled_distance_sq,
    output ready
  );
endinterface

// File: rtl/core/color_similarity_check_core.sv
// Pixel pair similarity check, redmean weighted colour distance.
// pair_i carries two RGB pixels per item, result_o one result per item:
// similar, exact_match, within_distance, within_brightness and the
// distance squared and scaled by 256. Both channels use valid/ready and
// an item moves at a clock edge with both high.
// Four register stages: channel differences, squares and luma products,
// weighted terms and luma sum, then the compare into the output register.
// One item is taken every cycle while the pipeline is not backed up.
// A stalled receiver holds the result in the output register; bubbles
// further up still fill, and pair_i.ready drops only once all four stages
// hold an item. Nothing is lost or repeated across a stall.
// The configuration port writes tolerance (index 0) and brightness limit
// (index 1); a write applies to items accepted at or after its clock edge.
// Reset empties the pipeline and loads tolerance 26 and brightness limit 20.
module color_similarity_check_core #(
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [csc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  csc_pair_if.sink                       pair_i,
  csc_result_if.source                   result_o
);
  import csc_pkg::*;

  localparam int unsigned LW = LUMA_FRAC_BITS + 12;

  cfg_t                 cfg;
  logic                 diff_valid, mult_valid;
  logic                 mult_rdy, decide_rdy;
  diff_t                diff;
  term_t                term;
  logic signed [LW-1:0] luma;

  // configuration registers
  csc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // stage one
  csc_diff u_diff (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pair_i     (pair_i),
    .next_rdy_i (mult_rdy),
    .valid_o    (diff_valid),
    .diff_o     (diff)
  );

  // stages two and three
  csc_mult #(
    .LUMA_FRAC_BITS (LUMA_FRAC_BITS)
  ) u_mult (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (diff_valid),
    .diff_i     (diff),
    .next_rdy_i (decide_rdy),
    .rdy_o      (mult_rdy),
    .valid_o    (mult_valid),
    .term_o     (term),
    .luma_o     (luma)
  );

  // stage four and output register
  csc_decide #(
    .LUMA_FRAC_BITS (LUMA_FRAC_BITS)
  ) u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mult_valid),
    .term_i   (term),
    .luma_i   (luma),
    .cfg_i    (cfg),
    .rdy_o    (decide_rdy),
    .result_o (result_o)
  );

endmodule

// File: rtl/core/csc_cfg.sv
module csc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [csc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [csc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output csc_pkg::cfg_t                 cfg_o
);
  import csc_pkg::*;

  logic [TOL_W-1:0]      tol_q, tol_d;
  logic [BRIGHT_W-1:0]   bright_q, bright_d;
  logic [BOUND_W-1:0]    bound_q, bound_d;
  logic [BOUND_SQ_W-1:0] bound_sq_q, bound_sq_d;

  // register write decode
  always_comb begin
    tol_d    = tol_q;
    bright_d = bright_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TOLERANCE:  tol_d    = cfg_wdata_i[TOL_W-1:0];
        CFG_BRIGHTNESS: bright_d = cfg_wdata_i[BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // distance bound 255*tol, then its square in the cycle after
  assign bound_d    = BOUND_W'(TOL_SCALE) * BOUND_W'(tol_q);
  assign bound_sq_d = BOUND_SQ_W'(bound_q) * BOUND_SQ_W'(bound_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= TOL_RST;
      bright_q   <= BRIGHT_RST;
      bound_q    <= BOUND_RST;
      bound_sq_q <= BOUND_SQ_RST;
    end else begin
      tol_q      <= tol_d;
      bright_q   <= bright_d;
      bound_q    <= bound_d;
      bound_sq_q <= bound_sq_d;
    end
  end

  assign cfg_o.bound_sq = bound_sq_q;
  assign cfg_o.bright   = bright_q;

  // squared bound has caught up once tolerance has held steady through the bound and squared-bound registers
  a_bound_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(tol_q) && $past($stable(tol_q)) |->
      bound_sq_q == (BOUND_SQ_W'(tol_q) * BOUND_SQ_W'(TOL_SCALE)) *
                    (BOUND_SQ_W'(tol_q) * BOUND_SQ_W'(TOL_SCALE)))
    else $error("distance bound out of step with tolerance");

endmodule

// File: rtl/core/csc_diff.sv
module csc_diff (
  input  logic          clk_i,
  input  logic          rst_ni,
  csc_pair_if.sink      pair_i,
  input  logic          next_rdy_i,
  output logic          valid_o,
  output csc_pkg::diff_t diff_o
);
  import csc_pkg::*;

  logic       valid_q;
  logic       rdy;
  diff_t      diff_d, diff_q;
  logic [DIFF_W-1:0] red_sum;

  assign rdy          = !valid_q || next_rdy_i;
  assign pair_i.ready = rdy;

  // absolute and signed channel differences, red mean, equality
  assign red_sum = {1'b0, pair_i.first_red} + {1'b0, pair_i.second_red};

  always_comb begin
    diff_d.dr = (pair_i.first_red >= pair_i.second_red) ?
                pair_i.first_red - pair_i.second_red :
                pair_i.second_red - pair_i.first_red;
    diff_d.dg = (pair_i.first_green >= pair_i.second_green) ?
                pair_i.first_green - pair_i.second_green :
                pair_i.second_green - pair_i.first_green;
    diff_d.db = (pair_i.first_blue >= pair_i.second_blue) ?
                pair_i.first_blue - pair_i.second_blue :
                pair_i.second_blue - pair_i.first_blue;
    diff_d.sdr = $signed({1'b0, pair_i.first_red}) - $signed({1'b0, pair_i.second_red});
    diff_d.sdg = $signed({1'b0, pair_i.first_green}) - $signed({1'b0, pair_i.second_green});
    diff_d.sdb = $signed({1'b0, pair_i.first_blue}) - $signed({1'b0, pair_i.second_blue});
    diff_d.m   = red_sum[DIFF_W-1:1];
    diff_d.exact = (pair_i.first_red == pair_i.second_red) &&
                   (pair_i.first_green == pair_i.second_green) &&
                   (pair_i.first_blue == pair_i.second_blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= pair_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && pair_i.valid) begin
      diff_q <= diff_d;
    end
  end

  assign valid_o = valid_q;
  assign diff_o  = diff_q;

  // equal pixels leave no difference in any channel
  a_exact_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && diff_q.exact |->
      diff_q.dr == '0 && diff_q.dg == '0 && diff_q.db == '0 && diff_q.sdg == '0)
    else $error("exact pair with nonzero difference");

endmodule

// File: rtl/core/csc_mult.sv
module csc_mult #(
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  csc_pkg::diff_t diff_i,
  input  logic           next_rdy_i,
  output logic           rdy_o,
  output logic           valid_o,
  output csc_pkg::term_t term_o,
  output logic signed [LUMA_FRAC_BITS+11:0] luma_o
);
  import csc_pkg::*;

  localparam int unsigned KW = LUMA_FRAC_BITS + 1;
  localparam int unsigned PW = KW + DIFF_W;
  localparam int unsigned LW = PW + 2;
  localparam longint unsigned LumaOne = 64'd1 << LUMA_FRAC_BITS;
  localparam longint unsigned KrVal = (64'd2126 * LumaOne + 64'd5000) / 64'd10000;
  localparam longint unsigned KgVal = (64'd7152 * LumaOne + 64'd5000) / 64'd10000;
  localparam longint unsigned KbVal = (64'd722 * LumaOne + 64'd5000) / 64'd10000;
  localparam logic signed [KW-1:0] KR = KW'(KrVal);
  localparam logic signed [KW-1:0] KG = KW'(KgVal);
  localparam logic signed [KW-1:0] KB = KW'(KbVal);

  // stage two: squares, weights, luma products
  logic                  v2_q, rdy2;
  logic [SQ_W-1:0]       dr2_q, dg2_q, db2_q;
  logic [WGT_W-1:0]      wr_q, wb_q;
  logic signed [PW-1:0]  pr_q, pg_q, pb_q;
  logic                  exact2_q;
  logic signed [DIFF_W-1:0] sdr, sdg, sdb;
  logic signed [PW-1:0]  pr_d, pg_d, pb_d;

  // stage three: weighted terms, luma difference
  logic                  v3_q, rdy3;
  term_t                 term_d, term_q;
  logic signed [LW-1:0]  luma_d, luma_q;

  assign rdy3  = !v3_q || next_rdy_i;
  assign rdy2  = !v2_q || rdy3;
  assign rdy_o = rdy2;

  assign sdr  = $signed(diff_i.sdr);
  assign sdg  = $signed(diff_i.sdg);
  assign sdb  = $signed(diff_i.sdb);
  assign pr_d = KR * sdr;
  assign pg_d = KG * sdg;
  assign pb_d = KB * sdb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= valid_i;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && valid_i) begin
      dr2_q    <= diff_i.dr * diff_i.dr;
      dg2_q    <= diff_i.dg * diff_i.dg;
      db2_q    <= diff_i.db * diff_i.db;
      wr_q     <= WGT_W'(RED_BASE) + {2'b00, diff_i.m};
      wb_q     <= WGT_W'(BLUE_BASE) - {2'b00, diff_i.m};
      pr_q     <= pr_d;
      pg_q     <= pg_d;
      pb_q     <= pb_d;
      exact2_q <= diff_i.exact;
    end
  end

  // weighted squares and the exact luma difference
  always_comb begin
    term_d.tr    = wr_q * dr2_q;
    term_d.tg    = {dg2_q, {GREEN_SHIFT{1'b0}}};
    term_d.tb    = wb_q * db2_q;
    term_d.exact = exact2_q;
    luma_d = $signed({{2{pr_q[PW-1]}}, pr_q}) + $signed({{2{pg_q[PW-1]}}, pg_q}) +
             $signed({{2{pb_q[PW-1]}}, pb_q});
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      term_q <= term_d;
      luma_q <= luma_d;
    end
  end

  assign valid_o = v3_q;
  assign term_o  = term_q;
  assign luma_o  = luma_q;

  // equal pixels carry no distance and no luma difference
  a_exact_terms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && term_q.exact |->
      luma_q == '0 && term_q.tr == '0 && term_q.tg == '0 && term_q.tb == '0)
    else $error("exact pair with nonzero terms");

endmodule

// File: rtl/core/csc_decide.sv
module csc_decide #(
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  csc_pkg::term_t term_i,
  input  logic signed [LUMA_FRAC_BITS+11:0] luma_i,
  input  csc_pkg::cfg_t  cfg_i,
  output logic           rdy_o,
  csc_result_if.source   result_o
);
  import csc_pkg::*;

  localparam int unsigned LW = LUMA_FRAC_BITS + 12;
  localparam int unsigned CMP_W = DIST_W + DIST_SHIFT;

  logic              v4_q, rdy;
  logic [DIST_W-1:0] dist_d, dist_q;
  logic              within_dist_d, within_bright_d;
  logic              similar_q, exact_q, within_dist_q, within_bright_q;
  logic [LW-1:0]     luma_mag, bright_lim;

  assign rdy   = !v4_q || result_o.ready;
  assign rdy_o = rdy;

  // scaled distance against the squared tolerance bound
  assign dist_d = {2'b00, term_i.tr} + {2'b00, term_i.tg} + {2'b00, term_i.tb};
  assign within_dist_d = {dist_d, {DIST_SHIFT{1'b0}}} <=
                         {{(CMP_W-BOUND_SQ_W){1'b0}}, cfg_i.bound_sq};

  // luma difference magnitude against the brightness limit
  assign luma_mag   = luma_i[LW-1] ? LW'(-luma_i) : LW'(luma_i);
  assign bright_lim = {{(LW-BRIGHT_W-LUMA_FRAC_BITS){1'b0}}, cfg_i.bright,
                       {LUMA_FRAC_BITS{1'b0}}};
  assign within_bright_d = luma_mag < bright_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy) begin
      v4_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) begin
      dist_q          <= dist_d;
      exact_q         <= term_i.exact;
      within_dist_q   <= within_dist_d;
      within_bright_q <= within_bright_d;
      similar_q       <= term_i.exact || (within_dist_d && within_bright_d);
    end
  end

  assign result_o.valid              = v4_q;
  assign result_o.similar            = similar_q;
  assign result_o.exact_match        = exact_q;
  assign result_o.within_distance    = within_dist_q;
  assign result_o.within_brightness  = within_bright_q;
  assign result_o.scaled_distance_sq = dist_q;

  // an exact match is similar, at zero distance and inside any bound
  a_exact_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && exact_q |-> similar_q && within_dist_q && dist_q == '0)
    else $error("exact match not reported as similar at zero distance");

endmodule

// File: tb/csc_tb_pkg.sv
`timescale 1ns / 100ps

package csc_tb_pkg;
  import csc_pkg::*;

  // redmean weights scaled by 256, and the tolerance step
  localparam longint unsigned RED_WEIGHT_BASE  = 512;
  localparam longint unsigned GREEN_WEIGHT     = 1024;
  localparam longint unsigned BLUE_WEIGHT_BASE = 767;
  localparam longint unsigned TOL_STEP_SCALE   = 255;
  localparam int unsigned     DIST_SCALE_SHIFT = 8;

  // luma coefficients in units of 1/10000
  localparam longint unsigned LUMA_RED_E4   = 2126;
  localparam longint unsigned LUMA_GREEN_E4 = 7152;
  localparam longint unsigned LUMA_BLUE_E4  = 722;
  localparam longint unsigned E4_SCALE      = 10000;

  // one pixel pair item
  typedef struct packed {
    logic [CHAN_W-1:0] r1;
    logic [CHAN_W-1:0] g1;
    logic [CHAN_W-1:0] b1;
    logic [CHAN_W-1:0] r2;
    logic [CHAN_W-1:0] g2;
    logic [CHAN_W-1:0] b2;
  } pixel_pair_t;

  // one similarity result item
  typedef struct packed {
    logic              similar;
    logic              exact_match;
    logic              within_distance;
    logic              within_brightness;
    logic [DIST_W-1:0] distance_sq;
  } similarity_t;

  class similarity_scoreboard;
    int unsigned         luma_frac;
    longint unsigned     coef_red;
    longint unsigned     coef_green;
    longint unsigned     coef_blue;
    logic [TOL_W-1:0]    tolerance;
    logic [BRIGHT_W-1:0] bright_limit;
    similarity_t         expected_results[$];
    int unsigned         failures;
    int unsigned         results_seen;
    int unsigned         similar_seen;
    int unsigned         exact_seen;
    int unsigned         near_seen;
    int unsigned         settings_used;

    function new(int unsigned frac);
      longint unsigned one;
      luma_frac     = frac;
      one           = 64'd1 << frac;
      // round half up to the nearest integer
      coef_red      = (LUMA_RED_E4 * one + E4_SCALE / 2) / E4_SCALE;
      coef_green    = (LUMA_GREEN_E4 * one + E4_SCALE / 2) / E4_SCALE;
      coef_blue     = (LUMA_BLUE_E4 * one + E4_SCALE / 2) / E4_SCALE;
      tolerance     = TOL_RST;
      bright_limit  = BRIGHT_RST;
      failures      = 0;
      results_seen  = 0;
      similar_seen  = 0;
      exact_seen    = 0;
      near_seen     = 0;
      settings_used = 1;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_TOLERANCE:  tolerance = value[TOL_W-1:0];
        CFG_BRIGHTNESS: bright_limit = value[BRIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function similarity_t predict_similarity(pixel_pair_t p);
      longint unsigned r1, g1, b1, r2, g2, b2;
      longint unsigned redmean, dr, dg, db, distance, bound, luma1, luma2, luma_gap, limit;
      similarity_t     s;
      r1 = p.r1;
      g1 = p.g1;
      b1 = p.b1;
      r2 = p.r2;
      g2 = p.g2;
      b2 = p.b2;

      // weighted squared distance, scaled by 256
      redmean  = (r1 + r2) >> 1;
      dr       = (r1 >= r2) ? r1 - r2 : r2 - r1;
      dg       = (g1 >= g2) ? g1 - g2 : g2 - g1;
      db       = (b1 >= b2) ? b1 - b2 : b2 - b1;
      distance = (RED_WEIGHT_BASE + redmean) * dr * dr + GREEN_WEIGHT * dg * dg
               + (BLUE_WEIGHT_BASE - redmean) * db * db;
      bound    = TOL_STEP_SCALE * tolerance;

      // fixed-point luminance difference, taken exactly
      luma1    = coef_red * r1 + coef_green * g1 + coef_blue * b1;
      luma2    = coef_red * r2 + coef_green * g2 + coef_blue * b2;
      luma_gap = (luma1 >= luma2) ? luma1 - luma2 : luma2 - luma1;
      limit    = bright_limit;
      limit    = limit << luma_frac;

      s.exact_match       = (r1 == r2) && (g1 == g2) && (b1 == b2);
      s.within_distance   = (distance << DIST_SCALE_SHIFT) <= bound * bound;
      s.within_brightness = luma_gap < limit;
      s.similar           = s.exact_match || (s.within_distance && s.within_brightness);
      s.distance_sq       = distance[DIST_W-1:0];
      return s;
    endfunction

    function void note_pair(pixel_pair_t p);
      expected_results.push_back(predict_similarity(p));
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(similarity_t got);
      similarity_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: result with no pair pending, got similar %0b distance %0d",
                 $time, got.similar, got.distance_sq);
        return;
      end
      want = expected_results.pop_front();
      compare_field("similar", want.similar, got.similar);
      compare_field("exact_match", want.exact_match, got.exact_match);
      compare_field("within_distance", want.within_distance, got.within_distance);
      compare_field("within_brightness", want.within_brightness, got.within_brightness);
      compare_field("scaled_distance_sq", want.distance_sq, got.distance_sq);
      if (want.similar) similar_seen++;
      if (want.exact_match) exact_seen++;
      if (want.within_distance && !want.exact_match) near_seen++;
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import csc_pkg::*;
  import csc_tb_pkg::*;

  localparam int unsigned LUMA_FRAC   = 16;
  localparam int unsigned PIPE_DEPTH  = 4;
  localparam int unsigned DRAIN_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int          CHAN_MAX    = 2 ** CHAN_W - 1;

  // corner pairs: extremes, single-channel swings, bound edges, exact matches
  localparam pixel_pair_t CORNER_PAIRS [15] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255},
    '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0},
    '{8'd255, 8'd0,   8'd0,   8'd254, 8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0},
    '{8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd255},
    '{8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd100, 8'd0,   8'd0,   8'd112, 8'd0},
    '{8'd0,   8'd100, 8'd0,   8'd0,   8'd113, 8'd0},
    '{8'd170, 8'd85,  8'd170, 8'd85,  8'd170, 8'd85},
    '{8'd85,  8'd170, 8'd85,  8'd170, 8'd85,  8'd170},
    '{8'd10,  8'd200, 8'd30,  8'd10,  8'd200, 8'd31},
    '{8'd128, 8'd64,  8'd32,  8'd128, 8'd64,  8'd32}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    steady_run;
  bit                    hold_off_req;

  similarity_scoreboard scoreboard = new(LUMA_FRAC);

  csc_pair_if   pair_if ();
  csc_result_if result_if ();

  color_similarity_check_core #(
    .LUMA_FRAC_BITS(LUMA_FRAC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pair_i     (pair_if),
    .result_o   (result_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // reset, driven low at start and released on a rising clock edge
  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("%0t: run timed out", $time);
    $display("Verification failed");
    $finish;
  end

  // result receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned stall;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (!steady_run && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 15);
        result_if.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk_i);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      scoreboard.check_result('{
        similar:           result_if.similar,
        exact_match:       result_if.exact_match,
        within_distance:   result_if.within_distance,
        within_brightness: result_if.within_brightness,
        distance_sq:       result_if.scaled_distance_sq
      });
    end
  end

  function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] level, int spread);
    int v;
    v = int'(level) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    else if (v > CHAN_MAX) v = CHAN_MAX;
    return CHAN_W'(v);
  endfunction

  // mostly near pairs, some exact, some unrelated, some single-channel changes
  function automatic pixel_pair_t random_pair();
    pixel_pair_t p;
    int          spread;
    p = 48'({$urandom(), $urandom()});
    case ($urandom_range(0, 9))
      0: begin
        p.r2 = p.r1;
        p.g2 = p.g1;
        p.b2 = p.b1;
      end
      1, 2: ;
      3: begin
        p.r2 = p.r1;
        p.g2 = p.g1;
        p.b2 = p.b1;
        case ($urandom_range(0, 2))
          0:       p.r2 = CHAN_W'($urandom_range(0, CHAN_MAX));
          1:       p.g2 = CHAN_W'($urandom_range(0, CHAN_MAX));
          default: p.b2 = CHAN_W'($urandom_range(0, CHAN_MAX));
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       spread = 2;
          1:       spread = 6;
          2:       spread = 16;
          default: spread = 48;
        endcase
        p.r2 = nudge(p.r1, spread);
        p.g2 = nudge(p.g1, spread);
        p.b2 = nudge(p.b1, spread);
      end
    endcase
    return p;
  endfunction

  task automatic send_pair(input pixel_pair_t p);
    pair_if.valid        <= 1'b1;
    pair_if.first_red    <= p.r1;
    pair_if.first_green  <= p.g1;
    pair_if.first_blue   <= p.b1;
    pair_if.second_red   <= p.r2;
    pair_if.second_green <= p.g2;
    pair_if.second_blue  <= p.b2;
    @(posedge clk_i);
    while (pair_if.ready !== 1'b1) @(posedge clk_i);
    scoreboard.note_pair(p);
  endtask

  // send one item, then maybe leave a gap
  task automatic offer_pair(input pixel_pair_t p);
    int unsigned gap;
    send_pair(p);
    if (!steady_run && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      pair_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) offer_pair(random_pair());
  endtask

  // stop offering and wait for every pending result, then let the pipeline settle
  task automatic wait_drain();
    int unsigned guard;
    guard = 0;
    pair_if.valid <= 1'b0;
    while (scoreboard.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (scoreboard.pending() != 0) begin
      scoreboard.failures++;
      $display("%0t: %0d results never arrived", $time, scoreboard.pending());
    end
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  // new thresholds, written only once the block is empty
  task automatic next_setting(logic [TOL_W-1:0] tol, logic [BRIGHT_W-1:0] bright);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_TOLERANCE;
    cfg_wdata <= CFG_DATA_W'(tol);
    @(posedge clk_i);
    cfg_idx   <= CFG_BRIGHTNESS;
    cfg_wdata <= CFG_DATA_W'(bright);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    scoreboard.write_register(CFG_TOLERANCE, CFG_DATA_W'(tol));
    scoreboard.write_register(CFG_BRIGHTNESS, CFG_DATA_W'(bright));
    scoreboard.settings_used++;
  endtask

  // stimulus
  initial begin
    pair_if.valid        <= 1'b0;
    pair_if.first_red    <= '0;
    pair_if.first_green  <= '0;
    pair_if.first_blue   <= '0;
    pair_if.second_red   <= '0;
    pair_if.second_green <= '0;
    pair_if.second_blue  <= '0;
    cfg_we               <= 1'b0;
    cfg_idx              <= CFG_TOLERANCE;
    cfg_wdata            <= '0;
    steady_run   = 1'b0;
    hold_off_req = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // reset thresholds: corner pairs then random items
    foreach (CORNER_PAIRS[i]) offer_pair(CORNER_PAIRS[i]);
    run_random(285);

    // zero tolerance and zero brightness limit
    next_setting(9'd0, 8'd0);
    run_random(200);

    // full tolerance, widest brightness limit
    next_setting(9'd256, 8'd255);
    run_random(250);

    // tolerance beyond one, tightest nonzero brightness limit
    next_setting(9'd511, 8'd1);
    run_random(200);

    next_setting(TOL_W'($urandom_range(0, 511)), BRIGHT_W'($urandom_range(0, 255)));
    run_random(250);

    // back to the reset thresholds; long receiver hold-off with a full pipeline
    next_setting(TOL_RST, BRIGHT_RST);
    run_random(100);
    wait_drain();
    steady_run   = 1'b1;
    hold_off_req = 1'b1;
    run_random(40);
    steady_run = 1'b0;
    run_random(110);

    // closing stretch with no idling on either side
    steady_run = 1'b1;
    next_setting(TOL_W'($urandom_range(13, 60)), BRIGHT_W'($urandom_range(5, 40)));
    run_random(250);

    wait_drain();
    $display("%0d pixel pairs checked under %0d threshold settings",
             scoreboard.results_seen, scoreboard.settings_used);
    $display("%0d similar, %0d exact matches, %0d inexact pairs within distance",
             scoreboard.similar_seen, scoreboard.exact_seen, scoreboard.near_seen);
    if (scoreboard.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
